// ===== hw/rtl/prre_pkg.sv =====
// shared types, constants and helpers of the plc read request encoder
package prre_pkg;

    // frame control characters
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;
    localparam logic [7:0] CMD_READ = 8'h30;
    localparam logic [7:0] CHR_ZERO = 8'h30;

    // hex digit encoding
    localparam logic [7:0] HEX_DIGIT_BASE = 8'h30;
    localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;
    localparam logic [7:0] HEX_DIGIT_LAST = 8'h39;
    localparam logic [7:0] HEX_ALPHA_FIRST = 8'h41;
    localparam logic [7:0] HEX_ALPHA_LAST = 8'h46;

    // device letters, upper case; lower case differs by one bit
    localparam logic [7:0] LTR_CASE_BIT = 8'h20;
    localparam logic [7:0] LTR_X = 8'h58;
    localparam logic [7:0] LTR_Y = 8'h59;
    localparam logic [7:0] LTR_M = 8'h4D;
    localparam logic [7:0] LTR_D = 8'h44;
    localparam logic [7:0] LTR_T = 8'h54;
    localparam logic [7:0] LTR_C = 8'h43;

    // device class held in the front register
    localparam logic [2:0] DEV_NONE = 3'd0;
    localparam logic [2:0] DEV_X = 3'd1;
    localparam logic [2:0] DEV_Y = 3'd2;
    localparam logic [2:0] DEV_M = 3'd3;
    localparam logic [2:0] DEV_D = 3'd4;
    localparam logic [2:0] DEV_T = 3'd5;
    localparam logic [2:0] DEV_C = 3'd6;

    // address bases
    localparam logic [15:0] BASE_X = 16'h0080;
    localparam logic [15:0] BASE_Y = 16'h00A0;
    localparam logic [15:0] BASE_M = 16'h0100;
    localparam logic [15:0] BASE_D = 16'h1000;
    localparam logic [15:0] BASE_T = 16'h0800;
    localparam logic [15:0] BASE_C = 16'h0A00;

    // reciprocal of ten: (a * RECIP_TEN) >> RECIP_SHIFT is exact for 16-bit a
    localparam logic [15:0] RECIP_TEN = 16'hCCCD;
    localparam int RECIP_SHIFT = 19;

    // frame kind
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_BIT = 2'd1;
    localparam logic [1:0] KIND_WORD = 2'd2;

    // byte positions in a frame
    localparam logic [3:0] POS_STX = 4'd0;
    localparam logic [3:0] POS_CMD = 4'd1;
    localparam logic [3:0] POS_A3 = 4'd2;
    localparam logic [3:0] POS_A2 = 4'd3;
    localparam logic [3:0] POS_A1 = 4'd4;
    localparam logic [3:0] POS_A0 = 4'd5;
    localparam logic [3:0] POS_L1 = 4'd6;
    localparam logic [3:0] POS_L0 = 4'd7;
    localparam logic [3:0] POS_ETX = 4'd8;
    localparam logic [3:0] POS_S1 = 4'd9;
    localparam logic [3:0] POS_S0 = 4'd10;

    localparam int PRRE_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  len;
    } t_entry;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        return (nib < 4'd10) ? HEX_DIGIT_BASE + wide : HEX_ALPHA_BASE + wide;
    endfunction

endpackage

// ===== hw/rtl/prre_if.sv =====
// request and frame byte channel interfaces
interface prre_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  device_letter;
    logic [15:0] element_address;
    logic [7:0]  element_count;

    modport source (output valid, output device_letter, output element_address,
                    output element_count, input ready);
    modport sink (input valid, input device_letter, input element_address,
                  input element_count, output ready);
endinterface

interface prre_frm_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

// ===== hw/rtl/prre_front.sv =====
// front part: accepts requests, classifies the device and maps the address
module prre_front
    import prre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    prre_req_if.sink    i_req,
    input  logic        i_q_full,
    output logic        o_push,
    output t_entry      o_entry
);

    logic        r_valid;
    logic [2:0]  r_dev;
    logic [15:0] r_a;
    logic [12:0] r_q;
    logic [7:0]  r_cnt;

    logic [2:0]  n_dev;
    logic [31:0] n_prod;
    logic        load;
    logic [3:0]  q10_lo;
    logic [3:0]  rem;
    logic [15:0] q8;
    logic [15:0] a2;

    assign load = !r_valid || o_push;
    assign i_req.ready = load;
    assign o_push = r_valid && !i_q_full;

    always_comb begin
        unique case (i_req.device_letter | LTR_CASE_BIT)
            LTR_X | LTR_CASE_BIT: n_dev = DEV_X;
            LTR_Y | LTR_CASE_BIT: n_dev = DEV_Y;
            LTR_M | LTR_CASE_BIT: n_dev = DEV_M;
            LTR_D | LTR_CASE_BIT: n_dev = DEV_D;
            LTR_T | LTR_CASE_BIT: n_dev = DEV_T;
            LTR_C | LTR_CASE_BIT: n_dev = DEV_C;
            default:              n_dev = DEV_NONE;
        endcase
        // only letters with bit 5 clear or set map; other codes that fold onto
        // a letter (none in ascii besides case) are excluded below
        if ((i_req.device_letter & ~LTR_CASE_BIT) != (i_req.device_letter | LTR_CASE_BIT)
                - LTR_CASE_BIT) begin
            n_dev = DEV_NONE;
        end
    end

    assign n_prod = i_req.element_address * RECIP_TEN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_req.valid) begin
            r_dev <= n_dev;
            r_a   <= i_req.element_address;
            r_q   <= n_prod[31:RECIP_SHIFT];
            r_cnt <= i_req.element_count;
        end
    end

    // remainder only needs the low nibble: a - 10q is below ten
    assign q10_lo = 4'({r_q[0], 3'b000} + {r_q[2:0], 1'b0});
    assign rem    = r_a[3:0] - q10_lo;
    assign q8     = {r_q, 3'b000};
    assign a2     = {r_a[14:0], 1'b0};

    always_comb begin
        o_entry.len = r_cnt;
        unique case (r_dev)
            DEV_X: begin
                o_entry.kind = KIND_BIT;
                o_entry.addr = q8 + {12'h000, rem} + BASE_X;
            end
            DEV_M: begin
                o_entry.kind = KIND_BIT;
                o_entry.addr = q8 + {12'h000, rem} + BASE_M;
            end
            DEV_Y: begin
                o_entry.kind = KIND_BIT;
                o_entry.addr = q8 + BASE_Y;
            end
            DEV_D: begin
                o_entry.kind = KIND_WORD;
                o_entry.addr = a2 + BASE_D;
                o_entry.len  = {r_cnt[6:0], 1'b0};
            end
            DEV_T: begin
                o_entry.kind = KIND_WORD;
                o_entry.addr = a2 + BASE_T;
                o_entry.len  = {r_cnt[6:0], 1'b0};
            end
            DEV_C: begin
                o_entry.kind = KIND_WORD;
                o_entry.addr = a2 + BASE_C;
                o_entry.len  = {r_cnt[6:0], 1'b0};
            end
            default: begin
                o_entry.kind = KIND_NONE;
                o_entry.addr = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/prre_queue.sv =====
// small queue of mapped requests between front and back
module prre_queue
    import prre_pkg::*;
#(
    parameter int DEPTH = PRRE_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_entry     i_entry,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_head_valid,
    output t_entry     o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_pop;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            unique case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== hw/rtl/prre_back.sv =====
// back part: walks the frame of the queue head, one byte per cycle while o_frm is not stalled
module prre_back
    import prre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_valid,
    input  t_entry      i_head,
    output logic        o_pop,
    prre_frm_if.source  o_frm
);

    logic        r_out_valid;
    logic [7:0]  r_byte;
    logic        r_end;
    logic [3:0]  r_idx;
    logic [7:0]  r_sum;

    logic        load;
    logic        emit;
    logic [7:0]  n_byte;
    logic [3:0]  n_idx;
    logic [7:0]  n_sum;

    assign load  = !r_out_valid || o_frm.ready;
    assign emit  = load && i_head_valid;
    assign o_pop = emit && (r_idx == POS_S0);

    assign o_frm.valid      = r_out_valid;
    assign o_frm.frame_byte = r_byte;
    assign o_frm.frame_end  = r_end;

    always_comb begin
        unique case (r_idx)
            POS_STX: n_byte = STX_BYTE;
            POS_CMD: n_byte = CMD_READ;
            POS_A3:  n_byte = (i_head.kind == KIND_WORD) ? hex_char(i_head.addr[15:12])
                                                         : CHR_ZERO;
            POS_A2:  n_byte = hex_char(i_head.addr[11:8]);
            POS_A1:  n_byte = hex_char(i_head.addr[7:4]);
            POS_A0:  n_byte = hex_char(i_head.addr[3:0]);
            POS_L1:  n_byte = hex_char(i_head.len[7:4]);
            POS_L0:  n_byte = hex_char(i_head.len[3:0]);
            POS_ETX: n_byte = ETX_BYTE;
            POS_S1:  n_byte = hex_char(r_sum[7:4]);
            POS_S0:  n_byte = hex_char(r_sum[3:0]);
            default: n_byte = STX_BYTE;
        endcase
    end

    always_comb begin
        priority if (r_idx == POS_STX && i_head.kind == KIND_NONE) begin
            n_idx = POS_ETX;
        end else if (r_idx == POS_S0) begin
            n_idx = POS_STX;
        end else begin
            n_idx = r_idx + 1'b1;
        end
    end

    // sum covers every byte after stx up to and including etx
    always_comb begin
        priority if (r_idx == POS_STX) begin
            n_sum = '0;
        end else if (r_idx <= POS_ETX) begin
            n_sum = r_sum + n_byte;
        end else begin
            n_sum = r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= POS_STX;
            r_sum       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= i_head_valid;
            end
            if (emit) begin
                r_idx <= n_idx;
                r_sum <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= n_byte;
            r_end  <= (r_idx == POS_S0);
        end
    end

endmodule

// ===== hw/rtl/plc_read_request_encoder_unit.sv =====
// top level of the plc read request encoder
//
// i_req carries one read request per transfer: device letter (x y m d t c,
// either case), element address and element count. o_frm gives the ascii
// request frame one byte per transfer, frame_end marking the last checksum
// byte. a frame is stx, '0', four address characters, two length
// characters, etx and two checksum characters: eleven bytes. an unknown
// device letter gives stx, etx and the checksum only: four bytes.
// a request passes the front register, the queue and the output register
// before its first frame byte is on o_frm.
// throughput: one frame byte per cycle while o_frm is not stalled; the byte
// sequencer of the back part sets it.
// the front part keeps taking requests into its register and the queue
// while the back part is busy or the receiver stalls; a stall on o_frm
// holds the byte in the output register and backs up into the queue and
// then into i_req.ready.
// reset (synchronous, active low) empties the front register, the queue
// and the output register and restarts the sequencer at stx.
module plc_read_request_encoder_unit
    import prre_pkg::*;
#(
    parameter int QUEUE_DEPTH = PRRE_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prre_req_if.sink   i_req,
    prre_frm_if.source o_frm
);

    // front to queue
    logic       push;
    logic       q_full;
    t_entry     push_entry;

    // queue to back
    logic       head_valid;
    t_entry     head;
    logic       pop;

    // front: registered divide-by-ten product, address map into the queue
    prre_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_q_full(q_full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    // decoupling queue of mapped requests
    prre_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_entry     (push_entry),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_head_valid(head_valid),
        .o_head      (head)
    );

    // back: byte sequencer with running checksum and output register
    prre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_valid(head_valid),
        .i_head      (head),
        .o_pop       (pop),
        .o_frm       (o_frm)
    );

endmodule

// ===== hw/rtl/prre_checker.sv =====
// port checker of the plc read request encoder, with its bind
module prre_checker
    import prre_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_frm_valid,
    input logic       i_frm_ready,
    input logic [7:0] i_frm_byte,
    input logic       i_frm_end
);

    logic r_first;
    logic frm_xfer;

    assign frm_xfer = i_frm_valid && i_frm_ready;

    // set while the next transfer opens a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (frm_xfer) begin
            r_first <= i_frm_end;
        end
    end

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frm_valid && !i_frm_ready |=>
            i_frm_valid && $stable(i_frm_byte) && $stable(i_frm_end))
        else $error("frame byte changed under stall");

    a_frame_opens_stx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frm_xfer && r_first |-> i_frm_byte == STX_BYTE && !i_frm_end)
        else $error("frame does not open with stx");

    a_no_stray_stx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frm_xfer && !r_first |-> i_frm_byte != STX_BYTE)
        else $error("stx inside a frame");

    a_end_is_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frm_valid && i_frm_end |->
            (i_frm_byte >= HEX_DIGIT_BASE && i_frm_byte <= HEX_DIGIT_LAST) ||
            (i_frm_byte >= HEX_ALPHA_FIRST && i_frm_byte <= HEX_ALPHA_LAST))
        else $error("last frame byte is not a hex character");

endmodule

bind plc_read_request_encoder_unit prre_checker u_prre_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_frm_valid(o_frm.valid),
    .i_frm_ready(o_frm.ready),
    .i_frm_byte (o_frm.frame_byte),
    .i_frm_end  (o_frm.frame_end)
);
